@@ hw/rtl/cbct_pkg.sv @@
// ----------------------------------------------------------------------------
// cbct_pkg
// Shared constants, types and register indexes for the centroid tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package cbct_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 24;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int RUN_BITS       = 5;
    localparam int ANGLE_BITS     = 16;
    localparam int QUEUE_DEPTH    = 4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_HIT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AOV_X     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AOV_Y     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TILT_OFF  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRE_RUN  = 3'd7;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_C,
        ST_ANG_MUL,
        ST_DIV_A,
        ST_DONE,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/color_blob_centroid_tracker.sv @@
// ----------------------------------------------------------------------------
// color_blob_centroid_tracker
// Red blob centroid and aim angle tracker over a pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid/in_ready, one transfer per clock; in_ready stays
// high unless the frame-total queue is full. Each pixel with end_of_frame
// pushes its frame totals into a four-entry queue and the accumulators clear.
// The back end pops one entry, runs the centroid long division (one quotient
// bit per cycle), forms the angle products and then runs both angle
// divisions in parallel; it pops no new entry until its result is taken.
// The result waits in the output register until out_ready; while it waits
// the next frame still accumulates, and only a full queue stalls the pixel
// side. Reset clears accumulators, queue pointers, the lock run and the
// sequencer state and loads the configuration defaults; the back end
// datapath registers have no reset.
// ----------------------------------------------------------------------------
`default_nettype none
module color_blob_centroid_tracker #(
    parameter int COORD_BITS = cbct_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = cbct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [cbct_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [cbct_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            blue,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            red,
    input  wire logic [COORD_BITS-1:0] pixel_x,
    input  wire logic [COORD_BITS-1:0] pixel_y,
    input  wire logic                  end_of_frame,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COORD_BITS-1:0]      centroid_x,
    output logic [COORD_BITS-1:0]      centroid_y,
    output logic [COUNT_BITS-1:0]      frame_hits,
    output logic                       target_seen,
    output logic                       locked,
    output logic signed [15:0]         pan_angle,
    output logic signed [15:0]         tilt_angle,
    output logic                       fire
);
    localparam int SUM_BITS = COORD_BITS + COUNT_BITS;
    localparam int QW = COUNT_BITS + 2 * SUM_BITS;

    logic [23:0] min_hit_reg;
    logic [7:0]  aov_x_reg, aov_y_reg, tilt_reg;
    logic [12:0] width_reg, height_reg;
    logic [6:0]  thr_reg;
    logic [4:0]  fire_run_reg;

    logic                  push, full, pop, avail, take;
    logic [COUNT_BITS-1:0] p_cnt;
    logic [SUM_BITS-1:0]   p_sx, p_sy;
    logic [QW-1:0]         q_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hit_reg  <= 24'd350;
            aov_x_reg    <= 8'd60;
            aov_y_reg    <= 8'd40;
            width_reg    <= 13'd640;
            height_reg   <= 13'd480;
            tilt_reg     <= 8'd20;
            thr_reg      <= 7'd70;
            fire_run_reg <= 5'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbct_pkg::REG_MIN_HIT:   min_hit_reg  <= cfg_data;
                cbct_pkg::REG_AOV_X:     aov_x_reg    <= cfg_data[7:0];
                cbct_pkg::REG_AOV_Y:     aov_y_reg    <= cfg_data[7:0];
                cbct_pkg::REG_WIDTH:     width_reg    <= cfg_data[12:0];
                cbct_pkg::REG_HEIGHT:    height_reg   <= cfg_data[12:0];
                cbct_pkg::REG_TILT_OFF:  tilt_reg     <= cfg_data[7:0];
                cbct_pkg::REG_THRESHOLD: thr_reg      <= cfg_data[6:0];
                cbct_pkg::REG_FIRE_RUN:  fire_run_reg <= cfg_data[4:0];
                default:                 ;
            endcase
        end
    end

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    cbct_front #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
        .clk, .rst_n, .blue, .green, .red, .pixel_x, .pixel_y, .end_of_frame,
        .take (take), .threshold (thr_reg), .push (push),
        .push_cnt (p_cnt), .push_sx (p_sx), .push_sy (p_sy)
    );

    cbct_queue #(.WIDTH(QW)) u_queue (
        .clk, .rst_n, .push (push), .push_data ({p_cnt, p_sx, p_sy}),
        .full (full), .pop (pop), .avail (avail), .pop_data (q_out)
    );

    cbct_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk, .rst_n, .avail (avail),
        .q_cnt (q_out[QW-1 -: COUNT_BITS]),
        .q_sx  (q_out[2*SUM_BITS-1 -: SUM_BITS]),
        .q_sy  (q_out[SUM_BITS-1:0]),
        .pop (pop), .min_hit (min_hit_reg), .aov_x (aov_x_reg), .aov_y (aov_y_reg),
        .fwidth (width_reg), .fheight (height_reg), .tilt_off ($signed(tilt_reg)),
        .fire_thr (fire_run_reg), .out_valid (out_valid), .out_ready (out_ready),
        .cx_o (centroid_x), .cy_o (centroid_y), .hits_o (frame_hits),
        .seen_o (target_seen), .locked_o (locked), .pan_o (pan_angle),
        .tilt_o (tilt_angle), .fire_o (fire)
    );
endmodule
`default_nettype wire

@@ hw/rtl/cbct_ram.sv @@
// ----------------------------------------------------------------------------
// cbct_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read, read data held when not enabled
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/cbct_front.sv @@
// ----------------------------------------------------------------------------
// cbct_front
// Pixel classifier and saturating frame accumulators; pushes frame totals.
// ----------------------------------------------------------------------------
`default_nettype none
module cbct_front #(
    parameter int COORD_BITS = cbct_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = cbct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [7:0]                       blue,
    input  wire logic [7:0]                       green,
    input  wire logic [7:0]                       red,
    input  wire logic [COORD_BITS-1:0]            pixel_x,
    input  wire logic [COORD_BITS-1:0]            pixel_y,
    input  wire logic                             end_of_frame,
    input  wire logic                             take,
    input  wire logic [6:0]                       threshold,
    output logic                                  push,
    output logic [COUNT_BITS-1:0]                 push_cnt,
    output logic [COORD_BITS+COUNT_BITS-1:0]      push_sx,
    output logic [COORD_BITS+COUNT_BITS-1:0]      push_sy
);
    localparam int SUM_BITS = COORD_BITS + COUNT_BITS;

    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [14:0]           lhs;
    logic [16:0]           rhs;
    logic                  hit;
    logic [COUNT_BITS:0]   cnt_sum;
    logic [SUM_BITS:0]     sx_sum, sy_sum;

    // hit test in exact integers
    assign lhs = 15'(red) * 15'd100;
    assign rhs = 17'(threshold) * (17'(blue) + 17'(green) + 17'(red));
    assign hit = 17'(lhs) > rhs;

    // saturating accumulation
    always_comb
    begin
        cnt_sum = {1'b0, cnt_reg} + 1'b1;
        sx_sum  = {1'b0, sx_reg} + (SUM_BITS+1)'(pixel_x);
        sy_sum  = {1'b0, sy_reg} + (SUM_BITS+1)'(pixel_y);
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        if (hit)
        begin
            cnt_next = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
            sx_next  = sx_sum[SUM_BITS] ? '1 : sx_sum[SUM_BITS-1:0];
            sy_next  = sy_sum[SUM_BITS] ? '1 : sy_sum[SUM_BITS-1:0];
        end
        push     = take && end_of_frame;
        push_cnt = cnt_next;
        push_sx  = sx_next;
        push_sy  = sy_next;
    end

    // accumulators clear after each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
        end
        else if (take)
        begin
            cnt_reg <= end_of_frame ? '0 : cnt_next;
            sx_reg  <= end_of_frame ? '0 : sx_next;
            sy_reg  <= end_of_frame ? '0 : sy_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/cbct_queue.sv @@
// ----------------------------------------------------------------------------
// cbct_queue
// Short frame-total queue between accumulator front and divider back end.
// ----------------------------------------------------------------------------
`default_nettype none
module cbct_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cbct_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  avail,
    output logic      [WIDTH-1:0] pop_data
);
    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] wp_reg, rp_reg, rp_next;
    logic [AW:0]   fill_reg;
    logic          rvalid_reg;
    logic          fetch;

    // read ahead one entry into the registered read port
    assign fetch   = (fill_reg != '0) && (!rvalid_reg || pop);
    assign rp_next = fetch ? rp_reg + 1'b1 : rp_reg;
    assign full    = fill_reg == (AW+1)'(DEPTH);
    assign avail   = rvalid_reg;

    cbct_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (push_data),
        .re    (fetch),
        .raddr (rp_reg),
        .rdata (pop_data)
    );

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            fill_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            rp_reg   <= rp_next;
            fill_reg <= fill_reg + (AW+1)'(push) - (AW+1)'(fetch);
            if (fetch)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                rvalid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/cbct_back.sv @@
// ----------------------------------------------------------------------------
// cbct_back
// End-of-frame sequencer: centroid and angle dividers, lock run, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
module cbct_back #(
    parameter int COORD_BITS = cbct_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = cbct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         avail,
    input  wire logic [COUNT_BITS-1:0]        q_cnt,
    input  wire logic [COORD_BITS+COUNT_BITS-1:0] q_sx,
    input  wire logic [COORD_BITS+COUNT_BITS-1:0] q_sy,
    output logic                              pop,
    input  wire logic [23:0]                  min_hit,
    input  wire logic [7:0]                   aov_x,
    input  wire logic [7:0]                   aov_y,
    input  wire logic [12:0]                  fwidth,
    input  wire logic [12:0]                  fheight,
    input  wire logic signed [7:0]            tilt_off,
    input  wire logic [4:0]                   fire_thr,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [COORD_BITS-1:0]             cx_o,
    output logic [COORD_BITS-1:0]             cy_o,
    output logic [COUNT_BITS-1:0]             hits_o,
    output logic                              seen_o,
    output logic                              locked_o,
    output logic signed [15:0]                pan_o,
    output logic signed [15:0]                tilt_o,
    output logic                              fire_o
);
    localparam int SUM_BITS = COORD_BITS + COUNT_BITS;
    // angle numerator: 128*a*sz - 256*pos*a + 256*off*sz, magnitude bound
    localparam int NUM_BITS = 40;
    localparam int CW       = $clog2(SUM_BITS + 1);
    localparam int AW_CNT   = $clog2(NUM_BITS + 1);

    cbct_pkg::back_state_t state_reg, state_next;

    logic [SUM_BITS-1:0]   sx_reg, sy_reg;          // become quotients
    logic [COUNT_BITS-1:0] rx_reg, ry_reg;          // remainders
    logic [COUNT_BITS-1:0] den_reg, hits_reg;
    logic [CW-1:0]         step_reg;
    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic                  seen_reg, lock_reg, fire_reg;
    logic [4:0]            run_reg;
    // angle division: magnitude long division, both axes side by side
    logic [NUM_BITS-1:0]   nx_reg, ny_reg;
    logic                  negx_reg, negy_reg;
    logic [12:0]           szx_reg, szy_reg;
    logic [13:0]           arx_reg, ary_reg;
    logic [AW_CNT-1:0]     astep_reg;
    logic signed [15:0]    pan_reg, tilt_reg;
    logic signed [NUM_BITS:0] prx_reg, pry_reg;     // pos*a products
    logic signed [NUM_BITS:0] bx_reg, by_reg;       // 128*a*sz, y adds 256*off*sz

    logic [COUNT_BITS:0] trx, try_;
    logic [13:0]         tax, tay;

    // one restoring step of each division
    always_comb
    begin
        trx  = {rx_reg, sx_reg[SUM_BITS-1]};
        try_ = {ry_reg, sy_reg[SUM_BITS-1]};
        tax  = {arx_reg[12:0], nx_reg[NUM_BITS-1]};
        tay  = {ary_reg[12:0], ny_reg[NUM_BITS-1]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbct_pkg::ST_IDLE:    if (avail) state_next = cbct_pkg::ST_DIV_C;
            cbct_pkg::ST_DIV_C:   if (step_reg == CW'(SUM_BITS - 1))
                                      state_next = cbct_pkg::ST_ANG_MUL;
            cbct_pkg::ST_ANG_MUL: state_next = cbct_pkg::ST_DIV_A;
            cbct_pkg::ST_DIV_A:   if (astep_reg == AW_CNT'(NUM_BITS))
                                      state_next = cbct_pkg::ST_DONE;
            cbct_pkg::ST_DONE:    state_next = cbct_pkg::ST_OUT;
            cbct_pkg::ST_OUT:     if (out_ready) state_next = cbct_pkg::ST_IDLE;
            default:              state_next = cbct_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop       = state_reg == cbct_pkg::ST_IDLE && avail;
        out_valid = state_reg == cbct_pkg::ST_OUT;
        cx_o      = cx_reg;
        cy_o      = cy_reg;
        hits_o    = hits_reg;
        seen_o    = seen_reg;
        locked_o  = lock_reg;
        pan_o     = pan_reg;
        tilt_o    = tilt_reg;
        fire_o    = fire_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbct_pkg::ST_IDLE;
            run_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cbct_pkg::ST_DONE && seen_reg)
            begin
                if (lock_reg)
                begin
                    if ((run_reg == 5'd31 ? run_reg : run_reg + 5'd1) > fire_thr)
                        run_reg <= '0;
                    else if (run_reg != 5'd31)
                        run_reg <= run_reg + 5'd1;
                end
                else
                begin
                    run_reg <= '0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cbct_pkg::ST_IDLE:
            begin
                sx_reg   <= q_sx;
                sy_reg   <= q_sy;
                rx_reg   <= '0;
                ry_reg   <= '0;
                hits_reg <= q_cnt;
                den_reg  <= (q_cnt == '0) ? COUNT_BITS'(1) : q_cnt;
                step_reg <= '0;
            end
            cbct_pkg::ST_DIV_C:
            begin
                step_reg <= step_reg + 1'b1;
                if (trx >= {1'b0, den_reg})
                begin
                    rx_reg <= COUNT_BITS'(trx - {1'b0, den_reg});
                    sx_reg <= {sx_reg[SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rx_reg <= trx[COUNT_BITS-1:0];
                    sx_reg <= {sx_reg[SUM_BITS-2:0], 1'b0};
                end
                if (try_ >= {1'b0, den_reg})
                begin
                    ry_reg <= COUNT_BITS'(try_ - {1'b0, den_reg});
                    sy_reg <= {sy_reg[SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    ry_reg <= try_[COUNT_BITS-1:0];
                    sy_reg <= {sy_reg[SUM_BITS-2:0], 1'b0};
                end
            end
            cbct_pkg::ST_ANG_MUL:
            begin
                // clamp centroid, form products
                cx_reg <= (sx_reg > SUM_BITS'({COORD_BITS{1'b1}})) ? '1
                          : sx_reg[COORD_BITS-1:0];
                cy_reg <= (sy_reg > SUM_BITS'({COORD_BITS{1'b1}})) ? '1
                          : sy_reg[COORD_BITS-1:0];
                seen_reg <= (sx_reg != '0) && (sy_reg != '0);
                lock_reg <= (sx_reg != '0) && (sy_reg != '0)
                            && (32'(den_reg) > 32'(min_hit));
                szx_reg <= (fwidth == '0) ? 13'd1 : fwidth;
                szy_reg <= (fheight == '0) ? 13'd1 : fheight;
                prx_reg <= (NUM_BITS+1)'($signed({1'b0,
                           ((sx_reg > SUM_BITS'({COORD_BITS{1'b1}})) ? {COORD_BITS{1'b1}}
                            : sx_reg[COORD_BITS-1:0])} * 21'(aov_x)));
                pry_reg <= (NUM_BITS+1)'($signed({1'b0,
                           ((sy_reg > SUM_BITS'({COORD_BITS{1'b1}})) ? {COORD_BITS{1'b1}}
                            : sy_reg[COORD_BITS-1:0])} * 21'(aov_y)));
                bx_reg  <= (NUM_BITS+1)'($signed({1'b0, 22'(aov_x) *
                           22'((fwidth == '0) ? 13'd1 : fwidth)})) <<< 7;
                by_reg  <= ((NUM_BITS+1)'($signed({1'b0, 22'(aov_y) *
                           22'((fheight == '0) ? 13'd1 : fheight)})) <<< 7)
                           + ((NUM_BITS+1)'($signed(tilt_off) *
                           $signed({1'b0, 22'((fheight == '0) ? 13'd1 : fheight)})) <<< 8);
                astep_reg <= '0;
            end
            cbct_pkg::ST_DIV_A:
            begin
                astep_reg <= astep_reg + 1'b1;
                if (astep_reg == '0)
                begin
                    // load magnitudes of numerators
                    nx_reg   <= NUM_BITS'(((bx_reg - (prx_reg <<< 8)) < 0)
                                ? -(bx_reg - (prx_reg <<< 8)) : (bx_reg - (prx_reg <<< 8)));
                    negx_reg <= (bx_reg - (prx_reg <<< 8)) < 0;
                    ny_reg   <= NUM_BITS'(((by_reg - (pry_reg <<< 8)) < 0)
                                ? -(by_reg - (pry_reg <<< 8)) : (by_reg - (pry_reg <<< 8)));
                    negy_reg <= (by_reg - (pry_reg <<< 8)) < 0;
                    arx_reg  <= '0;
                    ary_reg  <= '0;
                end
                else
                begin
                    if (tax >= {1'b0, szx_reg})
                    begin
                        arx_reg <= tax - {1'b0, szx_reg};
                        nx_reg  <= {nx_reg[NUM_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        arx_reg <= tax;
                        nx_reg  <= {nx_reg[NUM_BITS-2:0], 1'b0};
                    end
                    if (tay >= {1'b0, szy_reg})
                    begin
                        ary_reg <= tay - {1'b0, szy_reg};
                        ny_reg  <= {ny_reg[NUM_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        ary_reg <= tay;
                        ny_reg  <= {ny_reg[NUM_BITS-2:0], 1'b0};
                    end
                end
            end
            cbct_pkg::ST_DONE:
            begin
                // saturate signed quotients, gate by lock
                if (!lock_reg)
                    pan_reg <= '0;
                else if (negx_reg)
                    pan_reg <= (nx_reg > NUM_BITS'(32768)) ? 16'sh8000
                               : 16'(-$signed({1'b0, nx_reg}));
                else
                    pan_reg <= (nx_reg > NUM_BITS'(32767)) ? 16'sh7fff : 16'(nx_reg);
                if (!lock_reg)
                    tilt_reg <= '0;
                else if (negy_reg)
                    tilt_reg <= (ny_reg > NUM_BITS'(32768)) ? 16'sh8000
                                : 16'(-$signed({1'b0, ny_reg}));
                else
                    tilt_reg <= (ny_reg > NUM_BITS'(32767)) ? 16'sh7fff : 16'(ny_reg);
                fire_reg <= lock_reg && seen_reg &&
                            ((run_reg == 5'd31 ? run_reg : run_reg + 5'd1) > fire_thr);
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/cbct_checker.sv @@
// ----------------------------------------------------------------------------
// cbct_checker
// Port level checks for the centroid tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cbct_checker #(
    parameter int COORD_BITS = cbct_pkg::COORD_BITS_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  locked,
    input wire logic                  target_seen,
    input wire logic                  fire,
    input wire logic [COORD_BITS-1:0] centroid_x,
    input wire logic signed [15:0]    pan_angle
);
    // result stays valid and pan angle holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pan_angle))
        else $error("result changed while stalled");

    // lock implies seen
    a_lock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && locked |-> target_seen)
        else $error("locked without seen");

    // fire implies lock
    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fire |-> locked)
        else $error("fire without lock");

    // no angle without lock
    a_pan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !locked |-> pan_angle == 16'sd0)
        else $error("angle without lock");

    // seen needs a nonzero centroid
    a_seen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_seen |-> centroid_x != '0)
        else $error("seen with zero centroid");
endmodule

bind color_blob_centroid_tracker cbct_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk, .rst_n, .out_valid, .out_ready, .locked, .target_seen, .fire,
    .centroid_x, .pan_angle
);
`default_nettype wire

@@ dv/tb_color_blob_centroid_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_blob_centroid_tracker
// Self-checking bench for the red blob centroid and aim angle tracker.
// ----------------------------------------------------------------------------
// A short table of hand-picked pixels runs first, then framed random pixels
// under a series of register settings. Every accepted pixel goes through a
// local tracking model; each end-of-frame pushes the predicted summary, or
// a typed table row's own, and every output transfer is checked against the
// oldest one. Sender gaps, receiver stalls and one long receiver hold-off vary by phase.
// ----------------------------------------------------------------------------
module tb_color_blob_centroid_tracker;

    localparam int    COORD_BITS = cbct_pkg::COORD_BITS_DEF;
    localparam int    COUNT_BITS = cbct_pkg::COUNT_BITS_DEF;
    localparam longint COORD_MAX = (64'd1 << COORD_BITS) - 1;
    localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
    localparam longint SUM_MAX   = (64'd1 << (COORD_BITS + COUNT_BITS)) - 1;
    localparam longint RUN_MAX   = 31;
    localparam int    CYCLE_LIMIT = 1000000;
    localparam int    SETTLE_CYCLES = 150;
    localparam int    HOLD_CYCLES = 700;
    localparam int    PHASES = 10;
    localparam int    PHASE_ITEMS = 24;

    typedef struct {
        logic [7:0]            blue;
        logic [7:0]            green;
        logic [7:0]            red;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  eof;
    } pixel_t;

    typedef struct {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COUNT_BITS-1:0] hits;
        logic                  seen;
        logic                  lock;
        logic signed [15:0]    pan;
        logic signed [15:0]    tilt;
        logic                  fire;
    } frame_sum_t;

    typedef struct {
        pixel_t     pix;
        bit         typed;
        frame_sum_t sum;
    } dir_row_t;

    // dut ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [cbct_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [cbct_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] blue = '0;
    logic [7:0] green = '0;
    logic [7:0] red = '0;
    logic [COORD_BITS-1:0] pixel_x = '0;
    logic [COORD_BITS-1:0] pixel_y = '0;
    logic end_of_frame = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [COORD_BITS-1:0] centroid_x;
    logic [COORD_BITS-1:0] centroid_y;
    logic [COUNT_BITS-1:0] frame_hits;
    logic target_seen;
    logic locked;
    logic signed [15:0] pan_angle;
    logic signed [15:0] tilt_angle;
    logic fire;

    // tracking model state and register copy
    longint acc_hits, acc_sx, acc_sy, lock_run;
    logic [23:0] cfg_min_hit;
    logic [7:0]  cfg_aov_x, cfg_aov_y;
    logic [12:0] cfg_width, cfg_height;
    logic signed [7:0] cfg_tilt;
    logic [6:0]  cfg_thr;
    logic [4:0]  cfg_fire_run;

    frame_sum_t frame_sums_q[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    color_blob_centroid_tracker u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .blue(blue), .green(green), .red(red),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .end_of_frame(end_of_frame),
        .out_valid(out_valid), .out_ready(out_ready),
        .centroid_x(centroid_x), .centroid_y(centroid_y), .frame_hits(frame_hits),
        .target_seen(target_seen), .locked(locked),
        .pan_angle(pan_angle), .tilt_angle(tilt_angle), .fire(fire)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_color_blob_centroid_tracker: FAIL");
            $finish;
        end
    end

    // Q8 aim angle, truncated toward zero, saturated to 16 bits
    function automatic logic signed [15:0] aim_q8(longint aov, longint pos, longint size,
                                                  longint off);
        longint sz, num, q;
        sz  = (size == 0) ? 1 : size;
        num = 128 * aov * sz - 256 * pos * aov + 256 * off * sz;
        q   = num / sz;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic void clear_tracker();
        acc_hits = 0;
        acc_sx   = 0;
        acc_sy   = 0;
        lock_run = 0;
        cfg_min_hit  = 24'd350;
        cfg_aov_x    = 8'd60;
        cfg_aov_y    = 8'd40;
        cfg_width    = 13'd640;
        cfg_height   = 13'd480;
        cfg_tilt     = 8'sd20;
        cfg_thr      = 7'd70;
        cfg_fire_run = 5'd20;
    endfunction

    // accumulate one pixel; on end of frame build the frame summary
    function automatic bit track_pixel(input pixel_t p, output frame_sum_t s);
        longint cnt, cx, cy;
        bit seen_f;
        s = '{default: '0};
        if (100 * longint'(p.red) >
            longint'(cfg_thr) * (longint'(p.blue) + longint'(p.green) + longint'(p.red)))
        begin
            if (acc_hits < COUNT_MAX) acc_hits++;
            acc_sx = (acc_sx + p.px > SUM_MAX) ? SUM_MAX : acc_sx + p.px;
            acc_sy = (acc_sy + p.py > SUM_MAX) ? SUM_MAX : acc_sy + p.py;
        end
        if (!p.eof)
            return 1'b0;
        cnt = (acc_hits == 0) ? 1 : acc_hits;
        cx  = acc_sx / cnt;
        cy  = acc_sy / cnt;
        if (cx > COORD_MAX) cx = COORD_MAX;
        if (cy > COORD_MAX) cy = COORD_MAX;
        seen_f = (cx > 0) && (cy > 0);
        if (seen_f)
        begin
            if (cnt > longint'(cfg_min_hit))
            begin
                s.lock = 1'b1;
                s.pan  = aim_q8(cfg_aov_x, cx, cfg_width, 0);
                s.tilt = aim_q8(cfg_aov_y, cy, cfg_height, longint'(cfg_tilt));
                if (lock_run < RUN_MAX) lock_run++;
                if (lock_run > longint'(cfg_fire_run))
                begin
                    s.fire   = 1'b1;
                    lock_run = 0;
                end
            end
            else
                lock_run = 0;
        end
        s.cx   = cx[COORD_BITS-1:0];
        s.cy   = cy[COORD_BITS-1:0];
        s.hits = acc_hits[COUNT_BITS-1:0];
        s.seen = seen_f;
        acc_hits = 0;
        acc_sx   = 0;
        acc_sy   = 0;
        return 1'b1;
    endfunction

    // offer one pixel, wait for its transfer, and predict
    task automatic send_pixel(input pixel_t p, input bit typed, input frame_sum_t typed_sum);
        frame_sum_t s;
        frame_sum_t pick;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        blue         <= p.blue;
        green        <= p.green;
        red          <= p.red;
        pixel_x      <= p.px;
        pixel_y      <= p.py;
        end_of_frame <= p.eof;
        do
            @(posedge clk);
        while (!in_ready);
        if (track_pixel(p, s))
        begin
            pick = typed ? typed_sum : s;
            frame_sums_q.insert(frame_sums_q.size(), pick);
        end
    endtask

    // one register write; caller drops the write enable afterwards
    task automatic write_reg(input logic [cbct_pkg::CFG_IDX_BITS-1:0] idx,
                             input longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[cbct_pkg::CFG_DATA_BITS-1:0];
        @(posedge clk);
        case (idx)
            cbct_pkg::REG_MIN_HIT:   cfg_min_hit  = val[23:0];
            cbct_pkg::REG_AOV_X:     cfg_aov_x    = val[7:0];
            cbct_pkg::REG_AOV_Y:     cfg_aov_y    = val[7:0];
            cbct_pkg::REG_WIDTH:     cfg_width    = val[12:0];
            cbct_pkg::REG_HEIGHT:    cfg_height   = val[12:0];
            cbct_pkg::REG_TILT_OFF:  cfg_tilt     = val[7:0];
            cbct_pkg::REG_THRESHOLD: cfg_thr      = val[6:0];
            cbct_pkg::REG_FIRE_RUN:  cfg_fire_run = val[4:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input longint v[8]);
        write_reg(cbct_pkg::REG_MIN_HIT,   v[0]);
        write_reg(cbct_pkg::REG_AOV_X,     v[1]);
        write_reg(cbct_pkg::REG_AOV_Y,     v[2]);
        write_reg(cbct_pkg::REG_WIDTH,     v[3]);
        write_reg(cbct_pkg::REG_HEIGHT,    v[4]);
        write_reg(cbct_pkg::REG_TILT_OFF,  v[5]);
        write_reg(cbct_pkg::REG_THRESHOLD, v[6]);
        write_reg(cbct_pkg::REG_FIRE_RUN,  v[7]);
        cfg_we <= 1'b0;
    endtask

    // block idle: all summaries out, then room for anything still in flight
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (frame_sums_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pixel_t rand_pixel(input bit eof);
        pixel_t p;
        case ($urandom_range(3))
            0:
            begin
                p.blue  = $urandom_range(255);
                p.green = $urandom_range(255);
                p.red   = $urandom_range(255);
            end
            3:
            begin
                p.red   = $urandom_range(255);
                p.green = p.red;
                p.blue  = $urandom_range(255);
            end
            default:
            begin
                p.blue  = $urandom_range(40);
                p.green = $urandom_range(40);
                p.red   = $urandom_range(128, 255);
            end
        endcase
        p.px  = ($urandom_range(15) == 0) ? '0 : COORD_BITS'($urandom_range(4095));
        p.py  = ($urandom_range(15) == 0) ? '0 : COORD_BITS'($urandom_range(4095));
        p.eof = eof;
        return p;
    endfunction

    // long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result check and receiver ready
    always @(posedge clk)
    begin
        frame_sum_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_sums_q.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                e = frame_sums_q.pop_front();
                if (centroid_x !== e.cx)
                begin
                    $error("centroid_x exp %0d got %0d", e.cx, centroid_x);
                    errors++;
                end
                if (centroid_y !== e.cy)
                begin
                    $error("centroid_y exp %0d got %0d", e.cy, centroid_y);
                    errors++;
                end
                if (frame_hits !== e.hits)
                begin
                    $error("frame_hits exp %0d got %0d", e.hits, frame_hits);
                    errors++;
                end
                if (target_seen !== e.seen)
                begin
                    $error("target_seen exp %0d got %0d", e.seen, target_seen);
                    errors++;
                end
                if (locked !== e.lock)
                begin
                    $error("locked exp %0d got %0d", e.lock, locked);
                    errors++;
                end
                if (pan_angle !== e.pan)
                begin
                    $error("pan_angle exp %0d got %0d", e.pan, pan_angle);
                    errors++;
                end
                if (tilt_angle !== e.tilt)
                begin
                    $error("tilt_angle exp %0d got %0d", e.tilt, tilt_angle);
                    errors++;
                end
                if (fire !== e.fire)
                begin
                    $error("fire exp %0d got %0d", e.fire, fire);
                    errors++;
                end
            end
        end
        if (hold_left != 0 || (hold_req && !hold_done))
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // stimulus
    initial
    begin
        dir_row_t   rows[11];
        frame_sum_t zero_sum;
        longint     setting[8];
        pixel_t     p;
        int         n, len;

        zero_sum = '{default: '0};
        // hand-picked pixels under reset settings
        rows = '{
            '{'{8'd0,   8'd0,   8'd0,   12'd0,    12'd0,    1'b1}, 1'b1, zero_sum},
            '{'{8'd0,   8'd0,   8'd255, 12'd4095, 12'd4095, 1'b1}, 1'b1,
              '{12'd4095, 12'd4095, 24'd1, 1'b1, 1'b0, 16'sd0, 16'sd0, 1'b0}},
            '{'{8'd255, 8'd255, 8'd255, 12'd5,    12'd5,    1'b1}, 1'b1, zero_sum},
            '{'{8'd0,   8'd0,   8'd255, 12'd0,    12'd100,  1'b1}, 1'b1,
              '{12'd0, 12'd100, 24'd1, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
            '{'{8'd0,   8'd0,   8'd1,   12'd1,    12'd1,    1'b0}, 1'b0, zero_sum},
            '{'{8'd255, 8'd255, 8'd0,   12'd4095, 12'd0,    1'b0}, 1'b0, zero_sum},
            '{'{8'd10,  8'd10,  8'd255, 12'd3,    12'd7,    1'b1}, 1'b0, zero_sum},
            '{'{8'd255, 8'd0,   8'd255, 12'd2048, 12'd2048, 1'b1}, 1'b1, zero_sum},
            '{'{8'd0,   8'd255, 8'd255, 12'd1,    12'd1,    1'b0}, 1'b0, zero_sum},
            '{'{8'd1,   8'd1,   8'd255, 12'd4095, 12'd4095, 1'b0}, 1'b0, zero_sum},
            '{'{8'd0,   8'd0,   8'd128, 12'd4094, 12'd1,    1'b1}, 1'b0, zero_sum}
        };

        clear_tracker();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_pixel(rows[i].pix, rows[i].typed, rows[i].sum);

        // one large red frame so the reset hit minimum is exceeded
        for (int i = 0; i < 360; i++)
        begin
            p = rand_pixel(i == 359);
            p.blue = 8'd0;
            p.green = 8'd0;
            p.red = 8'd255;
            p.px = COORD_BITS'($urandom_range(1, 4095));
            p.py = COORD_BITS'($urandom_range(1, 4095));
            send_pixel(p, 1'b0, zero_sum);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: ;
                1: setting = '{0, 180, 180, 1, 1, -90, 0, 1};
                2: setting = '{2, 60, 40, 4096, 4096, 90, 50, 31};
                3: setting = '{16777215, 255, 255, 0, 0, -128, 127, 0};
                4: setting = '{1, 90, 90, 8191, 8191, 127, 100, 2};
                default:
                    setting = '{$urandom_range(8), $urandom_range(255), $urandom_range(255),
                                $urandom_range(8191), $urandom_range(8191),
                                $urandom_range(255), $urandom_range(80),
                                $urandom_range(31)};
            endcase
            if (ph != 0)
                apply_setting(setting);
            // idle mix rotates: none, sender gaps, receiver stalls, both
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 46; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            // long receiver hold-off while short frames keep coming
            if (ph == 4)
                hold_req = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                len = (ph == 4) ? $urandom_range(1, 3) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    send_pixel(rand_pixel(k == len - 1), 1'b0, zero_sum);
                    n++;
                end
            end
        end

        wait_drained();
        if (errors == 0)
            $display("tb_color_blob_centroid_tracker: PASS");
        else
            $display("tb_color_blob_centroid_tracker: FAIL");
        $finish;
    end

endmodule
